@@ hw/rtl/utf8_sanitizer_top_assert.svh @@
// ----------------------------------------------------------------------------
// utf8_sanitizer_top_assert.svh
// Assertion macros used by the sanitizer checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZER_TOP_ASSERT_SVH
`define UTF8_SANITIZER_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define UTF8S_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define UTF8S_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/utf8s_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8s_pkg
// Types, constants and helpers of the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf8s_pkg;

    localparam int UNITS_MAX  = 4;
    localparam int HELD_DEPTH = 3;

    // replacement character U+FFFD
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    localparam logic [1:0] SUB_FIRST = 2'd0;
    localparam logic [1:0] SUB_MID   = 2'd1;
    localparam logic [1:0] SUB_LAST  = 2'd2;

    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // one output unit: either a literal byte or a whole replacement char
    typedef struct packed {
        logic       repl;
        logic [7:0] lit;
    } t_unit;

    typedef struct packed {
        t_unit [UNITS_MAX-1:0] units;
        logic [2:0]            n_units;
        logic                  eot;
    } t_step_res;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_NONE;
        if (b >= 8'hC2 && b <= 8'hDF) begin
            len = LEN_TWO;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            len = LEN_THREE;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    // overlong / surrogate / out-of-range limits on the second byte
    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic ok;
        ok = 1'b1;
        if (lead == 8'hE0 && b < 8'hA0) ok = 1'b0;
        if (lead == 8'hED && b > 8'h9F) ok = 1'b0;
        if (lead == 8'hF0 && b < 8'h90) ok = 1'b0;
        if (lead == 8'hF4 && b > 8'h8F) ok = 1'b0;
        return ok;
    endfunction

    function automatic logic [7:0] repl_byte(input logic [1:0] sub);
        logic [7:0] v;
        unique case (sub)
            SUB_FIRST: v = REPL_B0;
            SUB_MID:   v = REPL_B1;
            SUB_LAST:  v = REPL_B2;
            default:   v = REPL_B2;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/utf8_sanitizer_top.sv @@
// ----------------------------------------------------------------------------
// utf8_sanitizer_top
// Streaming UTF-8 validator that replaces bad sequences with U+FFFD.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one raw byte per transaction in i_s_axis_tdata, with
//   i_s_axis_tlast high on the final byte of a text. Master stream: one
//   sanitized byte per transaction; o_m_axis_tlast marks the last byte
//   caused by one input byte, o_m_axis_tuser marks the last byte of a text.
//   An input byte is held in the input register, is decoded and lands in
//   the result register, from which its first output byte is offered.
//   Throughput: one input byte per cycle while every byte maps to at most
//   one output byte (ASCII, or leads and continuations that are only held)
//   and the receiver keeps i_m_axis_tready high. An input byte that yields
//   N output bytes occupies the result register until all N are taken
//   (N up to 12: up to four units of one literal byte or a three-byte
//   replacement). A completed 2..4 byte sequence is emitted as one output
//   byte per input byte it had, so valid text keeps one byte/cycle while
//   the receiver accepts. Bytes that produce no output pass the input
//   register even while the result register is busy.
//   Reset (i_rst_n low, synchronous) drops the open sequence and any
//   pending output. A stalled receiver holds the current byte stable; the
//   input register then fills and o_s_axis_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_sanitizer_top
    import utf8s_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // end_of_text
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,   // last_of_run
    output logic       o_m_axis_tuser    // [0] text_done
);

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_eot;

    // open-sequence state; held bytes are payload and need no reset
    logic [7:0] r_held [HELD_DEPTH];
    logic [1:0] r_held_cnt;
    logic [2:0] r_seq_len;

    t_step_res  step_res;
    logic [1:0] held_cnt_nx;
    logic [2:0] seq_len_nx;
    logic       held_we;
    logic [1:0] held_widx;
    logic       emit_free;
    logic       move;
    logic       load;
    logic       s_xfer;

    utf8s_step u_step (
        .i_byte        (r_s1_byte),
        .i_eot         (r_s1_eot),
        .i_held        (r_held),
        .i_held_cnt    (r_held_cnt),
        .i_seq_len     (r_seq_len),
        .o_res         (step_res),
        .o_held_cnt_nx (held_cnt_nx),
        .o_seq_len_nx  (seq_len_nx),
        .o_held_we     (held_we),
        .o_held_widx   (held_widx)
    );

    // a byte with no output may retire while the result register is busy
    assign move   = r_s1_valid && (step_res.n_units == 3'd0 || emit_free);
    assign load   = move && (step_res.n_units != 3'd0);
    assign o_s_axis_tready = !r_s1_valid || move;
    assign s_xfer = i_s_axis_tvalid && o_s_axis_tready;

    utf8s_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_res           (step_res),
        .o_free          (emit_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_held_cnt <= 2'd0;
            r_seq_len  <= LEN_NONE;
        end else begin
            if (s_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (move) begin
                r_s1_valid <= 1'b0;
            end
            if (move) begin
                r_held_cnt <= held_cnt_nx;
                r_seq_len  <= seq_len_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_s1_byte <= i_s_axis_tdata;
            r_s1_eot  <= i_s_axis_tlast;
        end
        if (move && held_we) begin
            r_held[held_widx] <= r_s1_byte;
        end
    end

endmodule

@@ hw/rtl/utf8s_step.sv @@
// ----------------------------------------------------------------------------
// utf8s_step
// Decodes one byte against the open sequence: output unit list and next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8s_step
    import utf8s_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    input  logic [7:0] i_held [HELD_DEPTH],
    input  logic [1:0] i_held_cnt,
    input  logic [2:0] i_seq_len,
    output t_step_res  o_res,
    output logic [1:0] o_held_cnt_nx,
    output logic [2:0] o_seq_len_nx,
    output logic       o_held_we,
    output logic [1:0] o_held_widx
);

    logic       cont_ok;
    logic [2:0] len;
    logic [1:0] nrep;
    logic       tail_en;
    logic       tail_repl;
    logic       pass;
    logic [7:0] src [UNITS_MAX];

    always_comb begin
        cont_ok = (i_byte[7:6] == 2'b10);
        if (i_held_cnt == 2'd1 && !second_ok(i_held[0], i_byte)) cont_ok = 1'b0;
        len           = lead_len(i_byte);
        nrep          = 2'd0;
        tail_en       = 1'b0;
        tail_repl     = 1'b0;
        pass          = 1'b0;
        o_held_cnt_nx = i_held_cnt;
        o_seq_len_nx  = i_seq_len;
        o_held_we     = 1'b0;
        o_held_widx   = i_held_cnt;

        if (i_held_cnt != 2'd0 && cont_ok) begin
            if ({1'b0, i_held_cnt} + 3'd1 == i_seq_len) begin
                // sequence complete: pass it through
                pass          = 1'b1;
                o_held_cnt_nx = 2'd0;
                o_seq_len_nx  = LEN_NONE;
            end else if (i_held_cnt != 2'd3) begin
                o_held_we = 1'b1;
                if (i_eot) begin
                    nrep          = i_held_cnt + 2'd1;
                    o_held_cnt_nx = 2'd0;
                    o_seq_len_nx  = LEN_NONE;
                end else begin
                    o_held_cnt_nx = i_held_cnt + 2'd1;
                end
            end else begin
                nrep          = 2'd3;
                o_held_cnt_nx = 2'd0;
                o_seq_len_nx  = LEN_NONE;
            end
        end else begin
            // flush whatever is held, then treat the byte as a new lead
            nrep          = i_held_cnt;
            o_held_cnt_nx = 2'd0;
            o_seq_len_nx  = LEN_NONE;
            if (!i_byte[7]) begin
                tail_en = 1'b1;
            end else if (len == LEN_NONE || i_eot) begin
                tail_en   = 1'b1;
                tail_repl = 1'b1;
            end else begin
                o_held_cnt_nx = 2'd1;
                o_seq_len_nx  = len;
                o_held_we     = 1'b1;
                o_held_widx   = 2'd0;
            end
        end
    end

    always_comb begin
        src[0] = i_held[0];
        src[1] = i_held[1];
        src[2] = i_held[2];
        src[3] = i_byte;
        for (int i = 0; i < UNITS_MAX; i++) begin
            o_res.units[i].repl = 1'b0;
            o_res.units[i].lit  = i_byte;
            if (pass) begin
                o_res.units[i].lit = (2'(i) == i_held_cnt) ? i_byte : src[i];
            end else if (2'(i) < nrep) begin
                o_res.units[i].repl = 1'b1;
            end else begin
                o_res.units[i].repl = tail_repl;
            end
        end
        o_res.n_units = pass ? ({1'b0, i_held_cnt} + 3'd1)
                             : ({1'b0, nrep} + {2'b00, tail_en});
        o_res.eot     = i_eot;
    end

endmodule

@@ hw/rtl/utf8s_emit.sv @@
// ----------------------------------------------------------------------------
// utf8s_emit
// Result register: walks the unit list of one input and drives the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8s_emit
    import utf8s_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_step_res  i_res,
    output logic       o_free,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,   // last_of_run
    output logic       o_m_axis_tuser    // [0] text_done
);

    logic                  r_valid, n_valid;
    t_unit [UNITS_MAX-1:0] r_units;
    logic [2:0]            r_n;
    logic                  r_eot;
    logic [1:0]            r_idx, n_idx;
    logic [1:0]            r_sub, n_sub;

    t_unit cur;
    logic  last;
    logic  xfer;

    assign cur  = r_units[r_idx];
    assign last = ({1'b0, r_idx} + 3'd1 == r_n) && (!cur.repl || r_sub == SUB_LAST);
    assign xfer = r_valid && i_m_axis_tready;

    assign o_free          = !r_valid || (xfer && last);
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = cur.repl ? repl_byte(r_sub) : cur.lit;
    assign o_m_axis_tlast  = last;
    assign o_m_axis_tuser  = last && r_eot;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        n_sub   = r_sub;
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = 2'd0;
            n_sub   = SUB_FIRST;
        end else if (xfer) begin
            if (last) begin
                n_valid = 1'b0;
            end else if (cur.repl && r_sub != SUB_LAST) begin
                n_sub = r_sub + 2'd1;
            end else begin
                n_idx = r_idx + 2'd1;
                n_sub = SUB_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
            r_sub   <= SUB_FIRST;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_units <= i_res.units;
            r_n     <= i_res.n_units;
            r_eot   <= i_res.eot;
        end
    end

endmodule

@@ hw/rtl/utf8s_checker.sv @@
// ----------------------------------------------------------------------------
// utf8s_checker
// Port-level checks on the sanitizer output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_sanitizer_top_assert.svh"

module utf8s_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] i_m_axis_tdata,
    input logic       i_m_axis_tlast,
    input logic       i_m_axis_tuser
);

    // stalled transaction must hold
    `UTF8S_ASSERT(a_stall_hold, i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tlast), "output changed while stalled")

    // end of text only on the last byte of a run
    `UTF8S_NEVER(a_done_last, i_m_axis_tvalid && i_m_axis_tuser && !i_m_axis_tlast, "text_done without last_of_run")

    // EF opens either a literal 3-byte sequence or a replacement: never last
    `UTF8S_NEVER(a_ef_not_last, i_m_axis_tvalid && i_m_axis_tdata == 8'hEF && i_m_axis_tlast, "EF ends a run")

    // bytes that never occur in well-formed UTF-8
    `UTF8S_NEVER(a_no_bad_byte, i_m_axis_tvalid && (i_m_axis_tdata == 8'hC0 || i_m_axis_tdata == 8'hC1 || i_m_axis_tdata >= 8'hF5), "illegal UTF-8 byte on output")

endmodule

bind utf8_sanitizer_top utf8s_checker u_utf8s_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tlast  (o_m_axis_tlast),
    .i_m_axis_tuser  (o_m_axis_tuser)
);
